@@ hdl/smd_pkg.sv @@
package smd_pkg;

    localparam int GAIN_W   = 24;
    localparam int MODE_W   = 2;
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 32;
    localparam int DT_W     = 16;
    localparam int CFG_A_W  = 2;

    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [GAIN_W-1:0] LAMBDA_RST = 24'd65536;
    localparam logic [GAIN_W-1:0] ALPHA_RST  = 24'd65536;
    localparam logic [GAIN_W-1:0] TGAIN_RST  = 24'd65536;

    // index of the last term in the exp series
    localparam logic [4:0] EXP_TERMS = 5'd24;

    typedef enum logic [MODE_W-1:0] {
        MODE_SIGN     = 2'd0,
        MODE_ZERO     = 2'd1,
        MODE_TANH     = 2'd2,
        MODE_SIGN_ALT = 2'd3
    } t_mode;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_LAMBDA = 2'd0,
        CFG_ALPHA  = 2'd1,
        CFG_TANH   = 2'd2,
        CFG_MODE   = 2'd3
    } t_cfg_idx;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hdl/smd_mul.sv @@
module smd_mul #(
    parameter int A_W = 33,
    parameter int B_W = 33
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ hdl/smd_div.sv @@
module smd_div #(
    parameter int DVD_W = 49,
    parameter int DVS_W = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    // restoring, one quotient bit a cycle; dividend shifts out as quotient shifts in
    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hdl/smd_sqrt.sv @@
module smd_sqrt #(
    parameter int RAD_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RAD_W-1:0]   i_rad,
    output logic               o_done,
    output logic [RAD_W/2-1:0] o_root
);

    localparam int RT_W  = RAD_W / 2;
    localparam int T_W   = RT_W + 4;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [RT_W+1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [T_W-1:0]   w_t;
    logic [T_W-1:0]   w_trial;
    logic             w_ge;

    // two radicand bits a cycle, one root bit out
    assign w_t     = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = T_W'({r_root, 2'b01});
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (RT_W+2)'(w_t - w_trial) : (RT_W+2)'(w_t);
            r_root <= {r_root[RT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hdl/sliding_mode_differentiator_unit.sv @@
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+-------------------------------------------
// input    | in  | i_valid / o_ready    | i_channel, i_sample, i_time_step
// result   | out | o_valid / i_ready    | o_channel_out, o_derivative
// config   | in  | i_cfg_wr_en          | i_cfg_addr, i_cfg_wdata
//
// One word in, one word out. Sign and zero modes use the 24-step root and ten
// products on the shared multiplier (two of them divide by three). Tanh mode adds the
// g*|e| product, and below saturation two exp series (each term a product and a
// 49-step divide), the em1 square, up to 31 scaling products and a final 49-step divide.
// o_ready is high only when the sequencer is idle; a finished word waits in the
// output register while the next word is taken. Synchronous active-low reset.
module sliding_mode_differentiator_unit #(
    parameter int CHANNELS  = smd_pkg::DEF_CHANNELS,
    parameter int FRAC_BITS = smd_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [smd_pkg::CH_W-1:0]          i_channel,
    input  logic signed [smd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [smd_pkg::DT_W-1:0]          i_time_step,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [smd_pkg::CH_W-1:0]          o_channel_out,
    output logic signed [smd_pkg::SAMPLE_W-1:0] o_derivative,
    input  logic                              i_cfg_wr_en,
    input  logic [smd_pkg::CFG_A_W-1:0]       i_cfg_addr,
    input  logic [smd_pkg::GAIN_W-1:0]        i_cfg_wdata
);

    import smd_pkg::*;

    localparam int RAD_W = 32 + FRAC_BITS + (FRAC_BITS % 2);
    localparam int SQ_W  = RAD_W / 2;
    localparam int M1_W  = GAIN_W + SQ_W - FRAC_BITS;
    localparam int MA_W  = (M1_W > 33) ? M1_W : 33;
    localparam int MB_W  = 33;
    localparam int P_W   = MA_W + MB_W;
    localparam int SM_W  = FRAC_BITS + 1;
    localparam int DVD_W = 33 + FRAC_BITS;
    localparam int DVS_W = 34;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SH    = 32 - 2 * FRAC_BITS;
    localparam int SHL   = (SH >= 0) ? SH : 0;
    localparam int SHR   = (SH < 0) ? -SH : 0;

    localparam logic [SM_W-1:0]  ONE_F  = SM_W'(1) << FRAC_BITS;
    localparam logic [32:0]      ONE32  = 33'h1_0000_0000;
    // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [MB_W-1:0]  RECIP3 = MB_W'(32'hAAAA_AAAB);
    localparam logic [31:0]      HALF32 = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_SQ_WAIT, S_LAM, S_M1, S_UCALC, S_V1, S_D2, S_D3, S_D4,
        S_DV6, S_DV24, S_ADVX, S_ADVU, S_FIN, S_MWAIT, S_DWAIT, S_TH_CHK,
        S_EXP_MUL, S_EXP_DIV, S_EXP_ACC, S_EXP_END, S_EM1, S_BIG_LOOP, S_BIG_ACC,
        S_TH_FIN
    } t_state;

    t_state r_state;
    t_state r_ret;

    logic [GAIN_W-1:0] r_lambda;
    logic [GAIN_W-1:0] r_alpha;
    logic [GAIN_W-1:0] r_tgain;
    t_mode             r_mode;

    logic signed [31:0] r_est [CHANNELS];
    logic signed [31:0] r_int [CHANNELS];

    logic [CH_W-1:0]     r_ch;
    logic                r_ch_ok;
    logic signed [31:0]  r_f;
    logic [DT_W-1:0]     r_dt;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_u1;
    logic [31:0]         r_abs_e;
    logic                r_eneg;
    logic                r_enz;
    logic [SQ_W-1:0]     r_q;
    logic [SM_W-1:0]     r_smag;
    logic signed [31:0]  r_u;
    logic [GAIN_W-1:0]   r_v1mag;
    logic [31:0]         r_d2;
    logic [31:0]         r_d3;
    logic [31:0]         r_d4;
    logic [32:0]         r_poly;
    logic [MA_W-1:0]     r_ma;
    logic [MB_W-1:0]     r_mb;
    logic [32:0]         r_term;
    logic signed [34:0]  r_sum;
    logic [4:0]          r_k;
    logic [31:0]         r_er;
    logic                r_pass;
    logic [31:0]         r_em1;
    logic [32:0]         r_big;
    logic [4:0]          r_n;
    logic [31:0]         r_yfrac;
    logic                r_dv_start;
    logic [DVD_W-1:0]    r_dvd;
    logic [DVS_W-1:0]    r_dvs;
    logic                r_sq_start;
    logic [RAD_W-1:0]    r_rad;
    logic                r_ovalid;
    logic [CH_W-1:0]     r_och;
    logic signed [31:0]  r_oder;

    logic [P_W-1:0]      w_p;
    logic                w_div_done;
    logic [DVD_W-1:0]    w_quot;
    logic                w_sq_done;
    logic [SQ_W-1:0]     w_root;
    logic [IDX_W-1:0]    w_idx;
    logic                w_ch_ok_in;
    logic signed [32:0]  w_e;
    logic [31:0]         w_abs_e;
    logic [31:0]         w_d;
    logic [31:0]         w_abs_u;
    logic [32:0]         w_poly_fin;
    logic signed [63:0]  w_m;
    logic signed [63:0]  w_inc;
    logic signed [63:0]  w_u1_64;
    logic signed [63:0]  w_x64;
    logic [P_W-1:0]      w_y;
    logic [32:0]         w_big_c;

    smd_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_p   (w_p)
    );

    smd_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dv_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    smd_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_rad   (r_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_idx      = IDX_W'(r_ch);
    assign w_ch_ok_in = int'(i_channel) < CHANNELS;
    assign w_e        = 33'(r_est[w_idx]) - 33'(r_f);
    assign w_abs_e    = w_e[32] ? 32'(-w_e) : w_e[31:0];
    assign w_d        = {r_dt, 16'h0000};
    assign w_abs_u    = r_u[31] ? (~r_u + 32'd1) : r_u;
    assign w_poly_fin = r_poly + 33'(w_p >> 33);
    assign w_m        = signed'(64'(w_p >> FRAC_BITS));
    assign w_inc      = signed'(64'(w_p >> 32));
    assign w_u1_64    = 64'(r_u1);
    assign w_x64      = 64'(r_x);
    assign w_y        = (w_p << (1 + SHL)) >> SHR;
    assign w_big_c    = 33'(w_p >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= LAMBDA_RST;
            r_alpha  <= ALPHA_RST;
            r_tgain  <= TGAIN_RST;
            r_mode   <= MODE_SIGN;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LAMBDA: r_lambda <= i_cfg_wdata;
                CFG_ALPHA:  r_alpha  <= i_cfg_wdata;
                CFG_TANH:   r_tgain  <= i_cfg_wdata;
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_wdata[MODE_W-1:0]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_dv_start <= 1'b0;
            r_sq_start <= 1'b0;
            r_ovalid   <= 1'b0;
            r_smag     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_est[i] <= '0;
                r_int[i] <= '0;
            end
        end else begin
            r_dv_start <= 1'b0;
            r_sq_start <= 1'b0;
            // in S_FIN the output register is reloaded below instead
            if (r_ovalid && i_ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ch    <= i_channel;
                        r_ch_ok <= w_ch_ok_in;
                        r_f     <= i_sample;
                        r_dt    <= i_time_step;
                        r_state <= w_ch_ok_in ? S_READ : S_FIN;
                    end
                end
                S_READ: begin
                    r_x        <= r_est[w_idx];
                    r_u1       <= r_int[w_idx];
                    r_abs_e    <= w_abs_e;
                    r_eneg     <= w_e[32];
                    r_enz      <= (w_e != '0);
                    r_rad      <= RAD_W'(w_abs_e) << FRAC_BITS;
                    r_sq_start <= 1'b1;
                    r_state    <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (w_sq_done) begin
                        r_q <= w_root;
                        if (!r_enz || r_mode == MODE_ZERO) begin
                            r_smag  <= '0;
                            r_state <= S_LAM;
                        end else if (r_mode == MODE_TANH) begin
                            r_ma    <= MA_W'(r_abs_e);
                            r_mb    <= MB_W'(r_tgain);
                            r_ret   <= S_TH_CHK;
                            r_state <= S_MWAIT;
                        end else begin
                            r_smag  <= ONE_F;
                            r_state <= S_LAM;
                        end
                    end
                end
                S_LAM: begin
                    r_ma    <= MA_W'(r_q);
                    r_mb    <= MB_W'(r_lambda);
                    r_ret   <= S_M1;
                    r_state <= S_MWAIT;
                end
                S_M1: begin
                    r_ma    <= MA_W'(w_p >> FRAC_BITS);
                    r_mb    <= MB_W'(r_smag);
                    r_ret   <= S_UCALC;
                    r_state <= S_MWAIT;
                end
                S_UCALC: begin
                    // m is zero when the switching term is zero
                    r_u     <= sat32(r_eneg ? w_u1_64 + w_m : w_u1_64 - w_m);
                    r_ma    <= MA_W'(r_smag);
                    r_mb    <= MB_W'(r_alpha);
                    r_ret   <= S_V1;
                    r_state <= S_MWAIT;
                end
                S_V1: begin
                    r_v1mag <= GAIN_W'(w_p >> FRAC_BITS);
                    r_ma    <= MA_W'(w_d);
                    r_mb    <= MB_W'(w_d);
                    r_ret   <= S_D2;
                    r_state <= S_MWAIT;
                end
                S_D2: begin
                    r_d2    <= 32'(w_p >> 32);
                    r_ma    <= MA_W'(w_p >> 32);
                    r_mb    <= MB_W'(w_d);
                    r_ret   <= S_D3;
                    r_state <= S_MWAIT;
                end
                S_D3: begin
                    r_d3    <= 32'(w_p >> 32);
                    r_ma    <= MA_W'(w_p >> 32);
                    r_mb    <= MB_W'(w_d);
                    r_ret   <= S_D4;
                    r_state <= S_MWAIT;
                end
                S_D4: begin
                    r_d4    <= 32'(w_p >> 32);
                    // d3/6 taken as (d3/2)/3
                    r_ma    <= MA_W'(r_d3 >> 1);
                    r_mb    <= RECIP3;
                    r_ret   <= S_DV6;
                    r_state <= S_MWAIT;
                end
                S_DV6: begin
                    r_poly  <= 33'(w_d) + 33'(r_d2 >> 1) + 33'(w_p >> 33);
                    // d4/24 taken as (d4/8)/3
                    r_ma    <= MA_W'(r_d4 >> 3);
                    r_mb    <= RECIP3;
                    r_ret   <= S_DV24;
                    r_state <= S_MWAIT;
                end
                S_DV24: begin
                    r_poly  <= w_poly_fin;
                    r_ma    <= MA_W'(w_abs_u);
                    r_mb    <= w_poly_fin;
                    r_ret   <= S_ADVX;
                    r_state <= S_MWAIT;
                end
                S_ADVX: begin
                    r_est[w_idx] <= sat32(r_u[31] ? w_x64 - w_inc : w_x64 + w_inc);
                    r_ma         <= MA_W'(r_v1mag);
                    r_mb         <= r_poly;
                    r_ret        <= S_ADVU;
                    r_state      <= S_MWAIT;
                end
                S_ADVU: begin
                    // integral is driven by minus the switching term
                    r_int[w_idx] <= sat32(r_eneg ? w_u1_64 + w_inc : w_u1_64 - w_inc);
                    r_state      <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_och    <= r_ch;
                        r_oder   <= r_ch_ok ? r_u : '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_MWAIT: begin
                    r_state <= r_ret;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_state <= r_ret;
                    end
                end
                S_TH_CHK: begin
                    if (w_p >= (P_W'(16) << (2 * FRAC_BITS))) begin
                        r_smag  <= ONE_F;
                        r_state <= S_LAM;
                    end else begin
                        r_n     <= w_y[36:32];
                        r_yfrac <= w_y[31:0];
                        // first series gives exp(-1/2), squared below
                        r_er    <= HALF32;
                        r_pass  <= 1'b0;
                        r_term  <= ONE32;
                        r_sum   <= 35'sd4294967296;
                        r_k     <= 5'd1;
                        r_state <= S_EXP_MUL;
                    end
                end
                S_EXP_MUL: begin
                    r_ma    <= MA_W'(r_term);
                    r_mb    <= MB_W'(r_er);
                    r_ret   <= S_EXP_DIV;
                    r_state <= S_MWAIT;
                end
                S_EXP_DIV: begin
                    r_dvd      <= DVD_W'(w_p >> 32);
                    r_dvs      <= DVS_W'(r_k);
                    r_dv_start <= 1'b1;
                    r_ret      <= S_EXP_ACC;
                    r_state    <= S_DWAIT;
                end
                S_EXP_ACC: begin
                    r_sum <= r_k[0] ? r_sum - signed'(35'(w_quot))
                                    : r_sum + signed'(35'(w_quot));
                    // a zero term keeps every later term zero
                    if (r_k == EXP_TERMS || w_quot == '0) begin
                        r_state <= S_EXP_END;
                    end else begin
                        r_term  <= 33'(w_quot);
                        r_k     <= r_k + 5'd1;
                        r_state <= S_EXP_MUL;
                    end
                end
                S_EXP_END: begin
                    if (!r_pass) begin
                        r_ma    <= MA_W'(r_sum[32:0]);
                        r_mb    <= r_sum[32:0];
                        r_ret   <= S_EM1;
                        r_state <= S_MWAIT;
                    end else begin
                        r_big   <= r_sum[32:0];
                        r_state <= S_BIG_LOOP;
                    end
                end
                S_EM1: begin
                    r_em1   <= 32'(w_p >> 32);
                    r_er    <= r_yfrac;
                    r_pass  <= 1'b1;
                    r_term  <= ONE32;
                    r_sum   <= 35'sd4294967296;
                    r_k     <= 5'd1;
                    r_state <= S_EXP_MUL;
                end
                S_BIG_LOOP: begin
                    if (r_n == '0) begin
                        r_dvd      <= DVD_W'(ONE32 - r_big) << FRAC_BITS;
                        r_dvs      <= DVS_W'(ONE32) + DVS_W'(r_big);
                        r_dv_start <= 1'b1;
                        r_ret      <= S_TH_FIN;
                        r_state    <= S_DWAIT;
                    end else begin
                        r_ma    <= MA_W'(r_big);
                        r_mb    <= MB_W'(r_em1);
                        r_ret   <= S_BIG_ACC;
                        r_state <= S_MWAIT;
                    end
                end
                S_BIG_ACC: begin
                    r_big   <= w_big_c;
                    r_n     <= r_n - 5'd1;
                    r_state <= S_BIG_LOOP;
                end
                S_TH_FIN: begin
                    r_smag  <= SM_W'(w_quot);
                    r_state <= S_LAM;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_channel_out = r_och;
    assign o_derivative  = r_oder;

`ifndef SYNTH
    a_units_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_div_done && !w_sq_done))
        else $error("iterative unit finished while sequencer idle");

    a_switch_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smag <= ONE_F)
        else $error("switching magnitude above one");

    a_bad_channel_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !w_ch_ok_in) |=> (r_state == S_FIN))
        else $error("word for absent channel not sent straight to output");
`endif

endmodule
